// ===== rtl/fra_pkg.sv =====
// fra_pkg: shared types and constants of the free run allocator
// used by fra_cell and free_run_allocator_core; no dependencies
package fra_pkg;

   typedef enum logic [1:0] {
      CMD_TAKE    = 2'd0,
      CMD_GIVE    = 2'd1,
      CMD_TRIM    = 2'd2,
      CMD_RESERVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_OVERFLOW = 2'd1,
      STS_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_INITIAL_ROWS = 2'd0,
      CSR_GROWTH       = 2'd1,
      CSR_HEADROOM     = 2'd2,
      CSR_FLOOR        = 2'd3
   } csr_idx_type;

   localparam logic [31:0] INITIAL_ROWS_RESET = 32'd1024;
   localparam logic [6:0]  GROWTH_RESET       = 7'd24;
   localparam logic [6:0]  HEADROOM_RESET     = 7'd4;
   localparam logic [31:0] FLOOR_RESET        = 32'd256;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] run_start;
      logic [31:0] run_rows;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] taken_start;
      logic [31:0] pool_size;
      logic        pool_changed;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] len;
   } ent_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        wen;
      ent_type     wdata;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRAIL,
      ST_MUL,
      ST_GROW,
      ST_EDIT
   } state_type;

endpackage

// ===== rtl/fra_cell.sv =====
// fra_cell: one entry of the free run table, a link of the cell ring
// depends on fra_pkg
module fra_cell #(
   parameter int unsigned IW  = 6,
   parameter int unsigned IDX = 0
) (
   input  logic                 clock,
   input  fra_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]        q,
   input  logic [IW-1:0]        widx,
   input  fra_pkg::ent_type     from_left,
   input  fra_pkg::ent_type     from_right,
   output fra_pkg::ent_type     ent
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   fra_pkg::ent_type ent_ff;
   fra_pkg::ent_type ent_in;

   always_comb begin
      ent_in = ent_ff;
      case (ctl.op)
         fra_pkg::CELL_ROTATE: begin
            ent_in = from_right;
         end
         fra_pkg::CELL_INSERT: begin
            if (MY_IDX > q) begin
               ent_in = from_left;
            end else if (MY_IDX == q) begin
               ent_in = ctl.wdata;
            end
         end
         fra_pkg::CELL_DELETE: begin
            if (MY_IDX >= q) begin
               ent_in = from_right;
            end
         end
         default: begin
         end
      endcase
      if (ctl.wen && (MY_IDX == widx)) begin
         ent_in = ctl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

// ===== rtl/free_run_allocator_core.sv =====
// free_run_allocator_core: first-fit row allocator with a ring of table cells
// depends on fra_pkg and fra_cell
//
// usage: a command beat (take, give back, trim, reserve) is taken when start
// is high and busy is low. busy stays high while the command is worked on.
// the free run table is a ring of MAX_RUNS cells; a command first rotates the
// ring once around so the controller sees every entry in order at cell 0,
// then passes the trail, mul and grow states (trailing run, growth and trim
// products, growth decision) and the edit state, which edits the cells
// (insert and delete shift the cells by one place in parallel).
// the result beat shows on rsp_data with rsp_valid high for one cycle,
// registered from the edit state, and is taken at the edge that ends that
// cycle; a new command can be taken at that same edge, so commands are
// worked on one at a time.
// the result cannot be held off by the receiver.
// csr writes (csr_we, csr_idx, csr_wdata) take effect at once; writing the
// initial rows register reloads the table as one free run.
// reset loads the register defaults and a pool of 1024 rows as one run.
module free_run_allocator_core #(
   parameter int unsigned MAX_RUNS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fra_pkg::req_type req_data,
   output logic             rsp_valid,
   output fra_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_idx,
   input  logic [31:0]      csr_wdata
);

   localparam int unsigned IW = $clog2(MAX_RUNS);
   localparam int unsigned CW = $clog2(MAX_RUNS + 1);

   fra_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        pool_ff, pool_in;
   logic [31:0]        init_rows_ff, init_rows_in;
   logic [6:0]         growth_ff, growth_in;
   logic [6:0]         headroom_ff, headroom_in;
   logic [31:0]        floor_ff, floor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   fra_pkg::rsp_type   rsp_ff, rsp_in;

   fra_pkg::req_type   req_ff, req_in;
   logic [IW-1:0]      k_ff, k_in;
   logic               fit_found_ff, fit_found_in;
   logic [IW-1:0]      fit_idx_ff, fit_idx_in;
   fra_pkg::ent_type   fit_ff, fit_in;
   fra_pkg::ent_type   last_ff, last_in;
   logic               p_found_ff, p_found_in;
   logic [IW-1:0]      p_idx_ff, p_idx_in;
   fra_pkg::ent_type   nx_ff, nx_in;
   fra_pkg::ent_type   pv_ff, pv_in;
   fra_pkg::ent_type   prev_ff, prev_in;
   logic               trailing_ff, trailing_in;
   logic [31:0]        trail_ff, trail_in;
   logic [31:0]        used_ff, used_in;
   logic [38:0]        geo_prod_ff, geo_prod_in;
   logic [34:0]        trim_prod_ff, trim_prod_in;
   logic               grow_bad_ff, grow_bad_in;
   logic [31:0]        target_ff, target_in;
   logic [35:0]        wanted_ff, wanted_in;

   fra_pkg::ent_type      cell_ent [MAX_RUNS];
   fra_pkg::ent_type      head;
   fra_pkg::cell_ctl_type cell_ctl;
   logic [IW-1:0]         cell_q;
   logic [IW-1:0]         cell_widx;

   // edit decision
   fra_pkg::status_type e_status;
   logic [31:0]         e_taken;
   logic [31:0]         e_pool;
   logic [CW-1:0]       e_count;
   fra_pkg::cell_op_type e_op;
   logic [IW-1:0]       e_q;
   logic                e_wen;
   logic [IW-1:0]       e_widx;
   fra_pkg::ent_type    e_w;

   // ring of cells
   for (genvar i = 0; i < MAX_RUNS; i++) begin : g_cell
      fra_cell #(
         .IW  (IW),
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .q          (cell_q),
         .widx       (cell_widx),
         .from_left  (cell_ent[(i + MAX_RUNS - 1) % MAX_RUNS]),
         .from_right (cell_ent[(i + 1) % MAX_RUNS]),
         .ent        (cell_ent[i])
      );
   end

   assign head = cell_ent[0];

   // scan capture: entry k sits at cell 0 during scan cycle k
   always_comb begin
      logic in_use;
      req_in       = req_ff;
      k_in         = k_ff;
      fit_found_in = fit_found_ff;
      fit_idx_in   = fit_idx_ff;
      fit_in       = fit_ff;
      last_in      = last_ff;
      p_found_in   = p_found_ff;
      p_idx_in     = p_idx_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      prev_in      = prev_ff;
      in_use       = (CW'(k_ff) < count_ff);
      if ((state_ff == fra_pkg::ST_IDLE) && start) begin
         req_in       = req_data;
         k_in         = '0;
         fit_found_in = 1'b0;
         p_found_in   = 1'b0;
         prev_in      = '0;
      end else if (state_ff == fra_pkg::ST_SCAN) begin
         k_in    = k_ff + IW'(1);
         prev_in = head;
         if (in_use && !fit_found_ff && (head.len >= req_ff.run_rows)) begin
            fit_found_in = 1'b1;
            fit_idx_in   = k_ff;
            fit_in       = head;
         end
         if ((CW'(k_ff) + CW'(1)) == count_ff) begin
            last_in = head;
         end
         // first entry starting above the returned run
         if (in_use && !p_found_ff && (head.start > req_ff.run_start)) begin
            p_found_in = 1'b1;
            p_idx_in   = k_ff;
            nx_in      = head;
            pv_in      = prev_ff;
         end
      end
   end

   // trailing run, products and growth decision
   always_comb begin
      logic [31:0] pool_nz;
      logic [31:0] shortfall;
      logic [32:0] sum;
      logic [34:0] geo;
      logic [31:0] geo_cl;
      logic [31:0] tgt;
      logic [35:0] want;
      trailing_in  = trailing_ff;
      trail_in     = trail_ff;
      used_in      = used_ff;
      geo_prod_in  = geo_prod_ff;
      trim_prod_in = trim_prod_ff;
      grow_bad_in  = grow_bad_ff;
      target_in    = target_ff;
      wanted_in    = wanted_ff;
      pool_nz      = (pool_ff == 32'd0) ? 32'd1 : pool_ff;
      shortfall    = (req_ff.run_rows > trail_ff) ? (req_ff.run_rows - trail_ff) : 32'd0;
      sum          = {1'b0, pool_ff} + {1'b0, shortfall};
      geo          = geo_prod_ff[38:4];
      geo_cl       = (|geo[34:32]) ? 32'hFFFF_FFFF : geo[31:0];
      tgt          = (geo_cl > sum[31:0]) ? geo_cl : sum[31:0];
      want         = 36'(used_ff) + 36'(trim_prod_ff);
      if (want < 36'(floor_ff)) begin
         want = 36'(floor_ff);
      end
      case (state_ff)
         fra_pkg::ST_TRAIL: begin
            trailing_in = (count_ff != '0) && ((last_ff.start + last_ff.len) == pool_ff);
            trail_in    = trailing_in ? last_ff.len : 32'd0;
            used_in     = pool_ff - trail_in;
         end
         fra_pkg::ST_MUL: begin
            geo_prod_in  = 39'(pool_nz) * 39'(growth_ff);
            trim_prod_in = 35'(used_ff[31:4]) * 35'(headroom_ff);
         end
         fra_pkg::ST_GROW: begin
            grow_bad_in = sum[32] || (tgt <= pool_ff);
            target_in   = tgt;
            wanted_in   = want;
         end
         default: begin
         end
      endcase
   end

   // edit decision for the command
   always_comb begin
      logic [31:0]      ext_target;
      logic [31:0]      added;
      logic [CW-1:0]    cnt_m1;
      logic [IW-1:0]    last_idx;
      logic [IW-1:0]    app_idx;
      logic             full;
      logic             cut_go;
      logic             appended;
      logic [IW-1:0]    f;
      fra_pkg::ent_type fe;
      logic [CW-1:0]    p_val;
      logic [CW-1:0]    p_m1;
      fra_pkg::ent_type pv_e;
      logic             nx_hit;
      logic             pv_hit;
      logic [31:0]      freed;
      ext_target = (req_ff.cmd == fra_pkg::CMD_RESERVE) ? req_ff.run_rows : target_ff;
      added      = ext_target - pool_ff;
      cnt_m1     = count_ff - CW'(1);
      last_idx   = cnt_m1[IW-1:0];
      app_idx    = count_ff[IW-1:0];
      full       = (count_ff == CW'(MAX_RUNS));
      cut_go     = 1'b0;
      appended   = 1'b0;
      f          = fit_idx_ff;
      fe         = fit_ff;
      p_val      = p_found_ff ? CW'(p_idx_ff) : count_ff;
      p_m1       = p_val - CW'(1);
      pv_e       = p_found_ff ? pv_ff : last_ff;
      nx_hit     = p_found_ff && ((req_ff.run_start + req_ff.run_rows) == nx_ff.start);
      pv_hit     = (p_val != '0) && ((pv_e.start + pv_e.len) == req_ff.run_start);
      freed      = pool_ff - wanted_ff[31:0];
      e_status   = fra_pkg::STS_OK;
      e_taken    = 32'd0;
      e_pool     = pool_ff;
      e_count    = count_ff;
      e_op       = fra_pkg::CELL_HOLD;
      e_q        = '0;
      e_wen      = 1'b0;
      e_widx     = '0;
      e_w        = '0;
      case (req_ff.cmd)
         fra_pkg::CMD_TAKE: begin
            if (fit_found_ff) begin
               cut_go = 1'b1;
            end else if (grow_bad_ff) begin
               e_status = fra_pkg::STS_OVERFLOW;
            end else if (trailing_ff) begin
               f        = last_idx;
               fe.start = last_ff.start;
               fe.len   = last_ff.len + added;
               e_pool   = target_ff;
               cut_go   = 1'b1;
            end else if (full) begin
               e_status = fra_pkg::STS_FULL;
            end else begin
               f        = app_idx;
               fe.start = pool_ff;
               fe.len   = added;
               e_pool   = target_ff;
               appended = 1'b1;
               cut_go   = 1'b1;
            end
            if (cut_go) begin
               e_taken = fe.start;
               if (fe.len == req_ff.run_rows) begin
                  // run used up: drop it, or never add it
                  if (!appended) begin
                     e_op    = fra_pkg::CELL_DELETE;
                     e_q     = f;
                     e_count = cnt_m1;
                  end
               end else begin
                  e_wen       = 1'b1;
                  e_widx      = f;
                  e_w.start   = fe.start + req_ff.run_rows;
                  e_w.len     = fe.len - req_ff.run_rows;
                  if (appended) begin
                     e_count = count_ff + CW'(1);
                  end
               end
            end
         end
         fra_pkg::CMD_GIVE: begin
            if (req_ff.run_rows != 32'd0) begin
               if (nx_hit && pv_hit) begin
                  e_wen     = 1'b1;
                  e_widx    = p_m1[IW-1:0];
                  e_w.start = pv_e.start;
                  e_w.len   = pv_e.len + req_ff.run_rows + nx_ff.len;
                  e_op      = fra_pkg::CELL_DELETE;
                  e_q       = p_val[IW-1:0];
                  e_count   = cnt_m1;
               end else if (pv_hit) begin
                  e_wen     = 1'b1;
                  e_widx    = p_m1[IW-1:0];
                  e_w.start = pv_e.start;
                  e_w.len   = pv_e.len + req_ff.run_rows;
               end else if (nx_hit) begin
                  e_wen     = 1'b1;
                  e_widx    = p_val[IW-1:0];
                  e_w.start = req_ff.run_start;
                  e_w.len   = nx_ff.len + req_ff.run_rows;
               end else if (full) begin
                  e_status = fra_pkg::STS_FULL;
               end else begin
                  e_op      = fra_pkg::CELL_INSERT;
                  e_q       = p_val[IW-1:0];
                  e_w.start = req_ff.run_start;
                  e_w.len   = req_ff.run_rows;
                  e_count   = count_ff + CW'(1);
               end
            end
         end
         fra_pkg::CMD_TRIM: begin
            if ((trail_ff != 32'd0) && (wanted_ff < 36'(pool_ff)) &&
                !(freed < (pool_ff >> 3))) begin
               e_pool = wanted_ff[31:0];
               if (wanted_ff[31:0] <= last_ff.start) begin
                  e_count = cnt_m1;
               end else begin
                  e_wen     = 1'b1;
                  e_widx    = last_idx;
                  e_w.start = last_ff.start;
                  e_w.len   = wanted_ff[31:0] - last_ff.start;
               end
            end
         end
         default: begin
            if (req_ff.run_rows > pool_ff) begin
               if (trailing_ff) begin
                  e_wen     = 1'b1;
                  e_widx    = last_idx;
                  e_w.start = last_ff.start;
                  e_w.len   = last_ff.len + added;
                  e_pool    = req_ff.run_rows;
               end else if (full) begin
                  e_status = fra_pkg::STS_FULL;
               end else begin
                  e_wen     = 1'b1;
                  e_widx    = app_idx;
                  e_w.start = pool_ff;
                  e_w.len   = added;
                  e_count   = count_ff + CW'(1);
                  e_pool    = req_ff.run_rows;
               end
            end
         end
      endcase
   end

   // state machine, csr and cell control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pool_in      = pool_ff;
      init_rows_in = init_rows_ff;
      growth_in    = growth_ff;
      headroom_in  = headroom_ff;
      floor_in     = floor_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cell_ctl     = '0;
      cell_q       = '0;
      cell_widx    = '0;
      case (state_ff)
         fra_pkg::ST_IDLE: begin
            if (start) begin
               state_in = fra_pkg::ST_SCAN;
            end
         end
         fra_pkg::ST_SCAN: begin
            cell_ctl.op = fra_pkg::CELL_ROTATE;
            if (k_ff == IW'(MAX_RUNS - 1)) begin
               state_in = fra_pkg::ST_TRAIL;
            end
         end
         fra_pkg::ST_TRAIL: begin
            state_in = fra_pkg::ST_MUL;
         end
         fra_pkg::ST_MUL: begin
            state_in = fra_pkg::ST_GROW;
         end
         fra_pkg::ST_GROW: begin
            state_in = fra_pkg::ST_EDIT;
         end
         fra_pkg::ST_EDIT: begin
            state_in            = fra_pkg::ST_IDLE;
            cell_ctl.op         = e_op;
            cell_ctl.wen        = e_wen;
            cell_ctl.wdata      = e_w;
            cell_q              = e_q;
            cell_widx           = e_widx;
            count_in            = e_count;
            pool_in             = e_pool;
            rsp_valid_in        = 1'b1;
            rsp_in.status       = e_status;
            rsp_in.taken_start  = e_taken;
            rsp_in.pool_size    = e_pool;
            rsp_in.pool_changed = (e_pool != pool_ff);
         end
         default: begin
            state_in = fra_pkg::ST_IDLE;
         end
      endcase
      if (csr_we) begin
         case (fra_pkg::csr_idx_type'(csr_idx))
            fra_pkg::CSR_INITIAL_ROWS: begin
               init_rows_in         = csr_wdata;
               count_in             = CW'(1);
               pool_in              = csr_wdata;
               cell_ctl.op          = fra_pkg::CELL_HOLD;
               cell_ctl.wen         = 1'b1;
               cell_ctl.wdata.start = 32'd0;
               cell_ctl.wdata.len   = csr_wdata;
               cell_widx            = '0;
            end
            fra_pkg::CSR_GROWTH: begin
               growth_in = csr_wdata[6:0];
            end
            fra_pkg::CSR_HEADROOM: begin
               headroom_in = csr_wdata[6:0];
            end
            default: begin
               floor_in = csr_wdata;
            end
         endcase
      end
      if (reset) begin
         cell_ctl.op          = fra_pkg::CELL_HOLD;
         cell_ctl.wen         = 1'b1;
         cell_ctl.wdata.start = 32'd0;
         cell_ctl.wdata.len   = fra_pkg::INITIAL_ROWS_RESET;
         cell_widx            = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fra_pkg::ST_IDLE;
         count_ff     <= CW'(1);
         pool_ff      <= fra_pkg::INITIAL_ROWS_RESET;
         init_rows_ff <= fra_pkg::INITIAL_ROWS_RESET;
         growth_ff    <= fra_pkg::GROWTH_RESET;
         headroom_ff  <= fra_pkg::HEADROOM_RESET;
         floor_ff     <= fra_pkg::FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pool_ff      <= pool_in;
         init_rows_ff <= init_rows_in;
         growth_ff    <= growth_in;
         headroom_ff  <= headroom_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      req_ff       <= req_in;
      k_ff         <= k_in;
      fit_found_ff <= fit_found_in;
      fit_idx_ff   <= fit_idx_in;
      fit_ff       <= fit_in;
      last_ff      <= last_in;
      p_found_ff   <= p_found_in;
      p_idx_ff     <= p_idx_in;
      nx_ff        <= nx_in;
      pv_ff        <= pv_in;
      prev_ff      <= prev_in;
      trailing_ff  <= trailing_in;
      trail_ff     <= trail_in;
      used_ff      <= used_in;
      geo_prod_ff  <= geo_prod_in;
      trim_prod_ff <= trim_prod_in;
      grow_bad_ff  <= grow_bad_in;
      target_ff    <= target_in;
      wanted_ff    <= wanted_in;
   end

   assign busy      = (state_ff != fra_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RUNS))
      else $error("run count above table size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   a_rsp_from_edit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == fra_pkg::ST_EDIT))
      else $error("result beat without an edit cycle");

   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != fra_pkg::STS_OK) |->
         !rsp_data.pool_changed && (rsp_data.taken_start == 32'd0))
      else $error("failed command changed the pool");

endmodule
